// File: hw/rtl/tnfe_pkg.sv
// Package with the shared types and constants of the tar numeric field encoder.
package tnfe_pkg;

  localparam int unsigned IDX_W = 4;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] BIN_FLAG   = 8'h80;

  typedef struct packed {
    logic             valid;
    logic             bin;
    logic             err;
    logic [IDX_W-1:0] lidx;
  } field_ctl_t;

endpackage

// File: hw/rtl/tnfe_serializer.sv
// Output stage that holds one formatted field and sends it out one byte per cycle.
module tnfe_serializer #(
  parameter int unsigned MAX_FIELD_BYTES = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tnfe_pkg::field_ctl_t         ld_ctl,
  input  logic [8*MAX_FIELD_BYTES-1:0] ld_word,
  output logic                         ld_free,
  output logic                         out_valid,
  output logic [7:0]                   out_byte,
  output logic [3:0]                   out_byte_index,
  output logic                         out_is_binary,
  output logic                         out_overflow,
  output logic                         out_last
);

  localparam int unsigned BW = 8 * MAX_FIELD_BYTES;

  tnfe_pkg::field_ctl_t                ctl_r, ctl_nxt;
  logic [tnfe_pkg::IDX_W-1:0]          idx_r, idx_nxt;
  logic [BW-1:0]                       word_r, word_nxt;
  logic                                at_last;

  assign at_last = ctl_r.err || (idx_r == ctl_r.lidx);
  assign ld_free = !ctl_r.valid || at_last;

  always_comb begin
    ctl_nxt  = ctl_r;
    idx_nxt  = idx_r;
    word_nxt = word_r;
    if (ld_free) begin
      ctl_nxt  = ld_ctl;
      idx_nxt  = '0;
      word_nxt = ld_word;
    end else begin
      idx_nxt  = idx_r + 1'b1;
      word_nxt = {word_r[BW-9:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_nxt.valid;
    end
    ctl_r.bin  <= ctl_nxt.bin;
    ctl_r.err  <= ctl_nxt.err;
    ctl_r.lidx <= ctl_nxt.lidx;
    idx_r      <= idx_nxt;
    word_r     <= word_nxt;
  end

  assign out_valid      = ctl_r.valid;
  assign out_byte       = (ctl_r.err || (!ctl_r.bin && at_last)) ? 8'h00 : word_r[BW-1 -: 8];
  assign out_byte_index = ctl_r.err ? 4'd0 : idx_r;
  assign out_is_binary  = ctl_r.bin && !ctl_r.err;
  assign out_overflow   = ctl_r.err;
  assign out_last       = at_last;

endmodule

// File: hw/rtl/tar_numeric_field_encoder.sv
// Top level of the tar numeric field encoder: input stages, format choice and field build.
//
//   channel | ports                              | handshake
//   --------+------------------------------------+-------------------------------------
//   input   | in_value, in_field_length          | taken when start is high, busy low
//   result  | out_byte, out_byte_index,          | out_valid strobe, high for each byte
//           | out_is_binary, out_overflow, out_last |
//
// An item passes two register stages (range checks, then alignment) before the output stage.
// Each item sends L bytes, one per cycle, or a single error byte; the output stage sets the rate.
// A new item enters while the previous one is still being sent, so fields follow without gaps.
// Reset clears the valid bits of all stages; busy rises only when every stage is full.
// The receiver cannot stall, so results leave at the output stage's own pace.
module tar_numeric_field_encoder #(
  parameter int unsigned MAX_FIELD_BYTES = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_value,
  input  logic [3:0]  in_field_length,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic [3:0]  out_byte_index,
  output logic        out_is_binary,
  output logic        out_overflow,
  output logic        out_last
);

  localparam int unsigned MAXD = MAX_FIELD_BYTES - 1;
  localparam int unsigned OW   = 3 * MAXD;
  localparam int unsigned BW   = 8 * MAX_FIELD_BYTES;
  localparam logic [4:0]  MAXL = 5'(MAX_FIELD_BYTES);

  logic        s1_valid_r, s1_valid_nxt;
  logic [63:0] s1_value_r;
  logic [3:0]  s1_lidx_r;
  logic        s2_valid_r, s2_valid_nxt;
  logic [63:0] s2_value_r;
  logic [3:0]  s2_lidx_r;
  logic        s2_oct_r;
  logic        s2_bok_r;

  logic        accept, s1_free, s2_free, em_free;
  logic [4:0]  len_c;
  logic [3:0]  lidx_c;
  logic [5:0]  oct_sh, bin_sh, oct_al_sh;
  logic [6:0]  bin_al_sh;
  logic        oct_fit, bin_ok;
  logic [OW-1:0]    oct_al;
  logic [BW+63:0]   bin_wide;
  logic [BW-1:0]    bin_al, oct_word, ld_word;
  tnfe_pkg::field_ctl_t ld_ctl;

  assign s2_free = !s2_valid_r || em_free;
  assign s1_free = !s1_valid_r || s2_free;
  assign busy    = !s1_free;
  assign accept  = start && !busy;

  always_comb begin
    len_c = {1'b0, in_field_length};
    if (len_c < 5'd2) begin
      len_c = 5'd2;
    end
    if (len_c > MAXL) begin
      len_c = MAXL;
    end
    lidx_c = 4'(len_c - 5'd1);
  end

  assign s1_valid_nxt = s1_free ? accept : s1_valid_r;
  assign s2_valid_nxt = s2_free ? s1_valid_r : s2_valid_r;

  assign oct_sh  = 6'(s1_lidx_r) * 6'd3;
  assign bin_sh  = 6'({s1_lidx_r, 3'b111});
  assign oct_fit = (s1_value_r & ({64{1'b1}} << oct_sh)) == 64'd0;
  assign bin_ok  = (5'(s1_lidx_r) >= 5'd8) ||
                   ((s1_value_r & ({64{1'b1}} << bin_sh)) == 64'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
    if (s1_free) begin
      s1_value_r <= in_value;
      s1_lidx_r  <= lidx_c;
    end
    if (s2_free) begin
      s2_value_r <= s1_value_r;
      s2_lidx_r  <= s1_lidx_r;
      s2_oct_r   <= oct_fit;
      s2_bok_r   <= bin_ok;
    end
  end

  assign oct_al_sh = 6'(OW) - 6'(s2_lidx_r) * 6'd3;
  assign oct_al    = s2_value_r[OW-1:0] << oct_al_sh;
  assign bin_al_sh = 7'(MAXD) - 7'(s2_lidx_r);
  assign bin_wide  = {{BW{1'b0}}, s2_value_r} << {bin_al_sh, 3'b000};
  assign bin_al    = bin_wide[BW-1:0] | {tnfe_pkg::BIN_FLAG, {(BW-8){1'b0}}};

  always_comb begin
    oct_word = '0;
    for (int i = 0; i < MAXD; i++) begin
      oct_word[BW-1-8*i -: 8] = tnfe_pkg::ASCII_ZERO | {5'b00000, oct_al[OW-1-3*i -: 3]};
    end
  end

  always_comb begin
    ld_ctl.valid = s2_valid_r;
    ld_ctl.bin   = !s2_oct_r && s2_bok_r;
    ld_ctl.err   = !s2_oct_r && !s2_bok_r;
    ld_ctl.lidx  = s2_lidx_r;
    ld_word      = s2_oct_r ? oct_word : bin_al;
  end

  tnfe_serializer #(
    .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
  ) u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .ld_ctl         (ld_ctl),
    .ld_word        (ld_word),
    .ld_free        (em_free),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .out_byte_index (out_byte_index),
    .out_is_binary  (out_is_binary),
    .out_overflow   (out_overflow),
    .out_last       (out_last)
  );

endmodule
